@@ hdl/hgrp_pkg.sv @@
// Package: shared constants and types for the GET request parser.
`default_nettype none
package hgrp_pkg;
	localparam int MaxRequest = 2048;
	localparam int PosW = 12;
	localparam int QDepth = 4;
	localparam int QAw = 2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;

	typedef struct packed {
		logic [1:0] status;
		logic keep_alive;
		logic [15:0] body_length;
		logic [10:0] url_offset;
		logic [11:0] url_length;
		logic [10:0] host_offset;
		logic [11:0] host_length;
		logic [11:0] request_length;
	} result_t;

	function automatic logic [7:0] lc(input logic [7:0] c);
		lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_sp(input logic [7:0] c);
		is_sp = (c == 8'h20) || (c == 8'h09);
	endfunction

	function automatic logic [7:0] ch_get(input logic [4:0] i);
		case (i)
			5'd0: ch_get = "g";
			5'd1: ch_get = "e";
			5'd2: ch_get = "t";
			default: ch_get = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ch_ver(input logic [4:0] i);
		case (i)
			5'd0: ch_ver = "h";
			5'd1: ch_ver = "t";
			5'd2: ch_ver = "t";
			5'd3: ch_ver = "p";
			5'd4: ch_ver = "/";
			5'd5: ch_ver = "1";
			5'd6: ch_ver = ".";
			5'd7: ch_ver = "1";
			default: ch_ver = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ch_pfx(input logic [4:0] i);
		case (i)
			5'd0: ch_pfx = "h";
			5'd1: ch_pfx = "t";
			5'd2: ch_pfx = "t";
			5'd3: ch_pfx = "p";
			5'd4: ch_pfx = ":";
			5'd5: ch_pfx = "/";
			5'd6: ch_pfx = "/";
			default: ch_pfx = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ch_ka(input logic [4:0] i);
		case (i)
			5'd0: ch_ka = "k";
			5'd1: ch_ka = "e";
			5'd2: ch_ka = "e";
			5'd3: ch_ka = "p";
			5'd4: ch_ka = "-";
			5'd5: ch_ka = "a";
			5'd6: ch_ka = "l";
			5'd7: ch_ka = "i";
			5'd8: ch_ka = "v";
			5'd9: ch_ka = "e";
			default: ch_ka = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ch_hdr(input logic [1:0] k, input logic [4:0] i);
		logic [119:0] s;
		logic [3:0] idx;
		case (k)
			2'd0: s = {"connection:", 32'h0};
			2'd1: s = "content-length:";
			default: s = {"host:", 80'h0};
		endcase
		idx = i[3:0];
		ch_hdr = s[8'd119 - {idx, 3'b000} -: 8];
	endfunction

	function automatic logic [4:0] hdr_len(input logic [1:0] k);
		case (k)
			2'd0: hdr_len = 5'd11;
			2'd1: hdr_len = 5'd15;
			default: hdr_len = 5'd5;
		endcase
	endfunction
endpackage
`default_nettype wire

@@ hdl/hgrp_front.sv @@
// Front end: byte-serial request parser producing result records.
`default_nettype none
module hgrp_front import hgrp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic [7:0] c,
	output logic res_valid,
	output result_t res
);
	typedef enum logic [13:0] {
		P_METHOD = 14'h0001, P_URL_SKIP = 14'h0002, P_URL = 14'h0004,
		P_VER_SKIP = 14'h0008, P_VER = 14'h0010, P_HNAME = 14'h0020,
		P_HSKIP = 14'h0040, P_HVAL = 14'h0080, P_HOTHER = 14'h0100,
		P_BODY = 14'h0200, P_LF_NEXT = 14'h0400, P_LF_BAD = 14'h0800,
		P_LF_DONE = 14'h1000, P_LF_BODY = 14'h2000
	} phase_t;

	localparam logic [1:0] U_PATH = 2'd0, U_PREFIX = 2'd1, U_SEARCH = 2'd2, U_JUNK = 2'd3;
	localparam logic [1:0] H_CONN = 2'd0, H_CLEN = 2'd1, H_HOST = 2'd2;

	phase_t phase_q, ph;
	logic [4:0] mp_q, mp;
	logic [1:0] hk_q, hk;
	logic [3:0] lf_q, lf;
	logic [PosW-1:0] bp_q, ls_q, ls;
	logic [15:0] cv_q, cv, cl_q, cl;
	logic ka_q, ka;
	logic [PosW-1:0] t0_q, t1_q, t2_q, t3_q, t0, t1, t2, t3;
	logic [PosW-1:0] pos, np;
	logic [1:0] rs;
	logic fire_res;
	logic [19:0] prod;
	logic [4:0] mp1;
	logic [2:0] keep3;

	always_comb begin
		ph = phase_q; mp = mp_q; hk = hk_q; lf = lf_q; ls = ls_q;
		cv = cv_q; cl = cl_q; ka = ka_q;
		t0 = t0_q; t1 = t1_q; t2 = t2_q; t3 = t3_q;
		pos = bp_q; np = bp_q + 1'b1;
		fire_res = 1'b0; rs = ST_DONE;
		prod = 20'd0; mp1 = mp_q + 5'd1; keep3 = 3'd0;
		if (phase_q == P_LF_NEXT || phase_q == P_LF_BAD || phase_q == P_LF_DONE ||
			phase_q == P_LF_BODY) begin
			if (c != 8'h0A) begin
				fire_res = 1'b1; rs = ST_BAD;
			end else if (phase_q == P_LF_NEXT) begin
				ph = P_HNAME; mp = 5'd0; lf = 4'd7; ls = np;
			end else if (phase_q == P_LF_BAD) begin
				fire_res = 1'b1; rs = ST_BAD;
			end else if (phase_q == P_LF_DONE) begin
				fire_res = 1'b1; rs = ST_DONE;
			end else begin
				cl = cv_q; ph = P_BODY;
			end
		end else if (phase_q == P_BODY) begin
			if (cl_q > 16'd0) cl = cl_q - 16'd1;
			if (cl == 16'd0) fire_res = 1'b1;
		end else if (c == 8'h0A) begin
			fire_res = 1'b1; rs = ST_BAD;
		end else if (c == 8'h0D) begin
			case (phase_q)
				P_METHOD, P_URL_SKIP, P_URL, P_VER_SKIP: ph = P_LF_BAD;
				P_VER: ph = (mp_q == 5'd8 && !lf_q[3]) ? P_LF_NEXT : P_LF_BAD;
				P_HNAME: begin
					if (pos == ls_q) ph = (cv_q != 16'd0) ? P_LF_BODY : P_LF_DONE;
					else ph = P_LF_NEXT;
				end
				P_HSKIP: begin
					if (hk_q == H_HOST) begin
						t2 = pos; t3 = '0;
					end
					ph = P_LF_NEXT;
				end
				P_HVAL: begin
					if (hk_q == H_CONN && mp_q == 5'd10 && !lf_q[3]) ka = 1'b1;
					ph = P_LF_NEXT;
				end
				default: ph = P_LF_NEXT;
			endcase
		end else begin
			case (phase_q)
				P_METHOD: begin
					if (is_sp(c)) begin
						if (mp_q != 5'd3) lf[3] = 1'b1;
						ph = P_URL_SKIP;
					end else if (mp_q < 5'd3 && lc(c) == ch_get(mp_q)) begin
						mp = mp1;
					end else begin
						lf[3] = 1'b1; mp = 5'd4;
					end
				end
				P_URL_SKIP: begin
					if (!is_sp(c)) begin
						ph = P_URL; mp = 5'd0;
						if (c == "/") begin
							hk = U_PATH; t0 = pos; t1 = 12'd1;
						end else if (lc(c) == "h") begin
							hk = U_PREFIX; mp = 5'd1;
						end else begin
							hk = U_JUNK; lf[3] = 1'b1;
						end
					end
				end
				P_URL: begin
					if (is_sp(c)) begin
						if (hk_q != U_PATH) lf[3] = 1'b1;
						ph = P_VER_SKIP; mp = 5'd0;
					end else begin
						case (hk_q)
							U_PATH: t1 = t1_q + 12'd1;
							U_PREFIX: begin
								if (mp_q < 5'd7 && lc(c) == ch_pfx(mp_q)) begin
									mp = mp1;
									if (mp1 == 5'd7) hk = U_SEARCH;
								end else begin
									hk = U_JUNK; lf[3] = 1'b1;
								end
							end
							U_SEARCH: begin
								if (c == "/") begin
									hk = U_PATH; t0 = pos; t1 = 12'd1;
								end
							end
							default: ;
						endcase
					end
				end
				P_VER_SKIP, P_VER: begin
					if (!(phase_q == P_VER_SKIP && is_sp(c))) begin
						ph = P_VER;
						if (mp_q < 5'd8 && lc(c) == ch_ver(mp_q)) mp = mp1;
						else lf[3] = 1'b1;
					end
				end
				P_HNAME: begin
					for (int k = 0; k < 3; k++) begin
						if (lf_q[k] && (mp_q >= hdr_len(2'(k)) ||
							lc(c) != ch_hdr(2'(k), mp_q)))
							lf[k] = 1'b0;
					end
					mp = mp1;
					for (int k = 0; k < 3; k++)
						keep3[k] = lf[k] && (hdr_len(2'(k)) == mp1);
					if (keep3[0] || keep3[1] || keep3[2]) begin
						hk = keep3[0] ? H_CONN : (keep3[1] ? H_CLEN : H_HOST);
						ph = P_HSKIP; mp = 5'd0; lf = 4'd0;
						if (keep3[1] && !keep3[0]) cv = 16'd0;
						if (keep3[2] && !keep3[0] && !keep3[1]) t3 = '0;
					end else if (lf[2:0] == 3'd0) begin
						ph = P_HOTHER;
					end
				end
				P_HSKIP, P_HVAL: begin
					if (!(phase_q == P_HSKIP && is_sp(c))) begin
						ph = P_HVAL;
						if (hk_q == H_CONN) begin
							if (!lf_q[3] && mp_q < 5'd10 && lc(c) == ch_ka(mp_q)) mp = mp1;
							else lf[3] = 1'b1;
						end else if (hk_q == H_CLEN) begin
							if (!lf_q[3] && c >= "0" && c <= "9") begin
								prod = {4'd0, cv_q} * 20'd10 + {12'd0, c - 8'h30};
								cv = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
							end else begin
								lf[3] = 1'b1;
							end
						end else begin
							if (t3_q == '0) t2 = pos;
							t3 = t3_q + 12'd1;
						end
					end
				end
				default: ;
			endcase
		end
		if (!fire_res && {1'b0, np} >= 13'(MaxRequest)) begin
			fire_res = 1'b1; rs = ST_OVER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_METHOD; mp_q <= '0; hk_q <= '0; lf_q <= '0; bp_q <= '0;
			ls_q <= '0; cv_q <= '0; cl_q <= '0; ka_q <= 1'b0;
			t0_q <= '0; t1_q <= '0; t2_q <= '0; t3_q <= '0; res_valid <= 1'b0;
		end else begin
			res_valid <= in_fire && fire_res;
			if (in_fire) begin
				if (fire_res) begin
					phase_q <= P_METHOD; mp_q <= '0; hk_q <= '0; lf_q <= '0; bp_q <= '0;
					ls_q <= '0; cv_q <= '0; cl_q <= '0; ka_q <= 1'b0;
					t0_q <= '0; t1_q <= '0; t2_q <= '0; t3_q <= '0;
				end else begin
					phase_q <= ph; mp_q <= mp; hk_q <= hk; lf_q <= lf; bp_q <= np;
					ls_q <= ls; cv_q <= cv; cl_q <= cl; ka_q <= ka;
					t0_q <= t0; t1_q <= t1; t2_q <= t2; t3_q <= t3;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && fire_res) begin
			res.status <= rs;
			res.request_length <= np;
			if (rs == ST_DONE) begin
				res.keep_alive <= ka; res.body_length <= cv;
				res.url_offset <= t0[10:0]; res.url_length <= t1;
				res.host_offset <= t2[10:0]; res.host_length <= t3;
			end else begin
				res.keep_alive <= 1'b0; res.body_length <= '0;
				res.url_offset <= '0; res.url_length <= '0;
				res.host_offset <= '0; res.host_length <= '0;
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/hgrp_queue.sv @@
// Result queue between the parser and the output channel.
`default_nettype none
module hgrp_queue import hgrp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire result_t wr_data,
	input wire logic rd_en,
	output logic rd_valid,
	output result_t rd_data,
	output logic almost_full
);
	result_t mem [QDepth];
	logic [QAw-1:0] wp_q, rp_q;
	logic [QAw:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wp_q] <= wr_data;
	end
	assign rd_data = mem[rp_q];
	assign rd_valid = cnt_q != '0;
	// one slot kept for the result already in the front end's output register
	assign almost_full = cnt_q >= (QAw+1)'(QDepth - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAw+1)'(wr_en) - (QAw+1)'(rd_en);
		end
	end
endmodule
`default_nettype wire

@@ hdl/http_get_request_parser_unit.sv @@
// Top level: HTTP GET request parser with byte input and result output.
// Output path: a result passes through the front end's output register and then the result queue before it is shown.
// Throughput: one byte per cycle; input stalls while two or more results wait in the queue.
// Reset: arst_n clears parse state and empties the result queue.
`default_nettype none
module http_get_request_parser_unit import hgrp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic keep_alive,
	output logic [15:0] body_length,
	output logic [10:0] url_offset,
	output logic [11:0] url_length,
	output logic [10:0] host_offset,
	output logic [11:0] host_length,
	output logic [11:0] request_length
);
	logic in_fire, rv, af;
	result_t r, q;

	assign in_stall = af;
	assign in_fire = in_valid && !in_stall;

	hgrp_front u_front (.clk, .arst_n, .in_fire, .c(data_byte), .res_valid(rv), .res(r));
	hgrp_queue u_queue (.clk, .arst_n, .wr_en(rv), .wr_data(r),
		.rd_en(out_valid && !out_stall), .rd_valid(out_valid), .rd_data(q),
		.almost_full(af));

	assign status = q.status;
	assign keep_alive = q.keep_alive;
	assign body_length = q.body_length;
	assign url_offset = q.url_offset;
	assign url_length = q.url_length;
	assign host_offset = q.host_offset;
	assign host_length = q.host_length;
	assign request_length = q.request_length;
endmodule
`default_nettype wire

@@ hdl/hgrp_checker.sv @@
// Port-level checker for the request parser, bound to the top level.
`default_nettype none
module hgrp_checker import hgrp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] status,
	input wire logic [11:0] request_length,
	input wire logic [15:0] body_length
);
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_OVER) else $error("bad status code");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> request_length != 12'd0) else $error("zero request length");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> body_length == 16'd0)
		else $error("error result carries body length");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(request_length))
		else $error("stalled result changed");
	a_idle_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall) else $error("input stalled with empty queue");
endmodule
bind http_get_request_parser_unit hgrp_checker u_chk (.clk, .arst_n, .in_stall,
	.out_valid, .out_stall, .status, .request_length, .body_length);
`default_nettype wire
